### design/imh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_pkg: shared types and constants for the indexed min-heap
// Action and status codes, widths, controller state and command structs.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int KEY_BITS      = 10;
  localparam int KEY_SPACE     = 1024;
  localparam int FIELD_VAL     = 16;
  localparam int COUNT_BITS    = 11;
  localparam int DEF_CAPACITY  = 1024;
  localparam int DEF_VAL_BITS  = 16;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DEC    = 2'd1,
    ACT_POP    = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_PRESENT   = 3'd3,
    ST_ABSENT    = 3'd4,
    ST_SATURATED = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_POPRD,
    S_POPWR,
    S_UPRD,
    S_UPCMP,
    S_DNRD,
    S_DNCMP,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    clear;      // clear one key map entry
    logic    load;       // capture input item
    logic    map_rd;     // read heap at mapped slot
    logic    do_insert;  // place new entry at tail
    logic    do_dec;     // decrement entry at map slot
    logic    pop_rd;     // read root and tail
    logic    pop_take;   // capture root, drop its key
    logic    pop_wr;     // move tail to root
    logic    up_rd;      // read parent of cursor
    logic    up_swap;    // exchange cursor and parent
    logic    dn_rd;      // read children of cursor
    logic    dn_swap;    // exchange cursor and picked child
    logic    set_status;
    status_t status;
    logic    out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_t act;
    logic    present;
    logic    full;
    logic    empty;
    logic    val_zero;
    logic    at_root;
    logic    up_move;
    logic    dn_move;
    logic    last_zero;
    logic    clear_done;
  } stat_t;

endpackage

### design/imh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_if: valid/ready channel interfaces
// Request and response channels of the heap.
// ----------------------------------------------------------------------------
interface imh_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [9:0]  entry_key;
  logic [15:0] entry_value;
  modport source (output valid, action, entry_key, entry_value, input ready);
  modport sink   (input valid, action, entry_key, entry_value, output ready);
endinterface

interface imh_rsp_if;
  logic        valid;
  logic        ready;
  logic [9:0]  popped_key;
  logic [15:0] popped_value;
  logic [10:0] entry_count;
  logic [2:0]  status;
  modport source (output valid, popped_key, popped_value, entry_count, status,
                  input ready);
  modport sink   (input valid, popped_key, popped_value, entry_count, status,
                  output ready);
endinterface

### design/imh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_ram: generic dual-port RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

### design/imh_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_datapath: heap storage, position map and sift arithmetic
// Heap slots in one RAM, a swap split over two writes on its single write
// port; the key map RAM holds a present bit and a slot per key and is
// cleared by a pass over all keys after reset.
// ----------------------------------------------------------------------------
module imh_datapath import imh_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int VALUE_BITS = DEF_VAL_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output stat_t                 st,
  input  logic [1:0]            req_action,
  input  logic [KEY_BITS-1:0]   req_key,
  input  logic [FIELD_VAL-1:0]  req_value,
  output logic [KEY_BITS-1:0]   rsp_key,
  output logic [FIELD_VAL-1:0]  rsp_value,
  output logic [COUNT_BITS-1:0] rsp_count,
  output logic [2:0]            rsp_status
);
  localparam int AW = $clog2(CAPACITY);
  localparam int SW = AW + 1;
  localparam int EW = KEY_BITS + VALUE_BITS;
  localparam int MW = AW + 1;   // present bit over slot number

  // item registers
  action_t               act;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] val;
  logic [SW-1:0]         size;
  logic [AW-1:0]         pos;
  status_t               status;
  logic [KEY_BITS-1:0]   pkey;
  logic [VALUE_BITS-1:0] pval;
  logic [KEY_BITS-1:0]   clr_addr;

  // heap ram: port a reads the slot, root, parent or left child, port b the tail or right child
  logic          h_we;
  logic [AW-1:0] h_waddr, h_ra, h_rb;
  logic [EW-1:0] h_wdata, h_da, h_db;
  // map ram: both ports read the item key, a gives the slot, b the present bit
  logic                  m_we;
  logic [KEY_BITS-1:0]   m_waddr, m_ra;
  logic [MW-1:0]         m_wdata, m_da, m_db;

  // second write of a swap, done in the cycle after it
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic [EW-1:0] pend_data;
  logic [EW-1:0] cur, oth;   // moving entry / entry it trades places with
  logic [AW-1:0] oth_pos;

  imh_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr_a(h_ra), .rdata_a(h_da), .raddr_b(h_rb), .rdata_b(h_db));

  imh_ram #(.WIDTH(MW), .DEPTH(KEY_SPACE)) u_map (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr_a(m_ra), .rdata_a(m_da), .raddr_b(m_ra), .rdata_b(m_db));

  logic [VALUE_BITS-1:0] va, vb, vc;
  logic [AW-1:0] parent, left, right;
  logic [SW:0]   left_w, right_w;
  logic          has_l, has_r, pick_r;

  assign parent  = AW'((pos - AW'(1)) >> 1);
  assign left_w  = (SW+1)'({pos, 1'b0}) + (SW+1)'(1);
  assign right_w = left_w + (SW+1)'(1);
  assign left    = left_w[AW-1:0];
  assign right   = right_w[AW-1:0];
  assign has_l   = left_w < (SW+1)'(size);
  assign has_r   = right_w < (SW+1)'(size);
  assign va      = h_da[VALUE_BITS-1:0];
  assign vb      = h_db[VALUE_BITS-1:0];
  assign vc      = cur[VALUE_BITS-1:0];
  assign pick_r  = has_r && (vb < va);

  // status toward the controller
  always_comb begin
    st.act        = act;
    st.present    = m_db[AW];
    st.full       = size >= SW'(CAPACITY);
    st.empty      = size == '0;
    st.val_zero   = va == '0;
    st.at_root    = pos == '0;
    st.up_move    = va > vc;                       // parent in port a
    st.dn_move    = has_l && (pick_r ? (vb < vc) : (va < vc));
    st.last_zero  = size == SW'(1);
    st.clear_done = &clr_addr;
  end

  // read addresses; the map is read at the incoming key on the accept edge
  always_comb begin
    h_ra = '0;
    h_rb = '0;
    m_ra = cmd.load ? req_key : key;
    if (cmd.map_rd) h_ra = m_da[AW-1:0];
    if (cmd.pop_rd) begin h_ra = '0; h_rb = AW'(size - SW'(1)); end
    if (cmd.up_rd)  h_ra = parent;
    if (cmd.dn_rd)  begin h_ra = left; h_rb = right; end
  end

  // write ports
  always_comb begin
    h_we = pend; h_waddr = pend_addr; h_wdata = pend_data;
    m_we = pend; m_waddr = pend_data[EW-1:VALUE_BITS]; m_wdata = {1'b1, pend_addr};
    if (cmd.clear) begin
      m_we = 1'b1; m_waddr = clr_addr; m_wdata = '0;
    end else if (cmd.do_insert) begin
      h_we = 1'b1; h_waddr = AW'(size); h_wdata = {key, val};
      m_we = 1'b1; m_waddr = key; m_wdata = {1'b1, AW'(size)};
    end else if (cmd.do_dec) begin
      h_we = 1'b1; h_waddr = pos;
      h_wdata = {h_da[EW-1:VALUE_BITS], va - VALUE_BITS'(1)};
    end else if (cmd.pop_take) begin
      m_we = 1'b1; m_waddr = h_da[EW-1:VALUE_BITS]; m_wdata = '0;
    end else if (cmd.pop_wr) begin
      h_we = 1'b1; h_waddr = '0; h_wdata = cur;
      m_we = 1'b1; m_waddr = cur[EW-1:VALUE_BITS]; m_wdata = {1'b1, {AW{1'b0}}};
    end else if (cmd.up_swap || cmd.dn_swap) begin
      h_we = 1'b1; h_waddr = pos; h_wdata = oth;
      m_we = 1'b1; m_waddr = oth[EW-1:VALUE_BITS]; m_wdata = {1'b1, pos};
    end
  end

  always_comb begin
    oth = h_da; oth_pos = parent;
    if (cmd.dn_swap) begin
      oth     = pick_r ? h_db : h_da;
      oth_pos = pick_r ? right : left;
    end
  end

  // size, clearing pass and pending swap write
  always_ff @(posedge clk) begin
    if (rst) begin
      size     <= '0;
      pend     <= 1'b0;
      clr_addr <= '0;
    end else begin
      pend <= cmd.up_swap || cmd.dn_swap;
      if (cmd.clear) clr_addr <= clr_addr + KEY_BITS'(1);
      if (cmd.do_insert) size <= size + SW'(1);
      if (cmd.pop_take) size <= size - SW'(1);
    end
  end

  // item and cursor registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= action_t'(req_action);
      key  <= req_key;
      val  <= VALUE_BITS'(req_value);
      pkey <= '0;
      pval <= '0;
    end
    if (cmd.do_insert) begin
      pos <= AW'(size);
      cur <= {key, val};
    end
    if (cmd.map_rd) pos <= m_da[AW-1:0];
    if (cmd.do_dec) cur <= {h_da[EW-1:VALUE_BITS], va - VALUE_BITS'(1)};
    if (cmd.pop_take) begin
      pkey <= h_da[EW-1:VALUE_BITS];
      pval <= va;
      cur  <= h_db;
    end
    if (cmd.pop_wr) pos <= '0;
    if (cmd.up_swap || cmd.dn_swap) begin
      pend_addr <= oth_pos;
      pend_data <= cur;
      pos       <= oth_pos;
    end
    if (cmd.set_status) status <= cmd.status;
    // response register, loaded only when the slot is free
    if (cmd.out_load) begin
      rsp_key    <= pkey;
      rsp_value  <= FIELD_VAL'(pval);
      rsp_count  <= COUNT_BITS'(size);
      rsp_status <= status;
    end
  end
endmodule

### design/imh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_ctrl: sequencer of the heap actions
// Clears the key map after reset, checks the item, then walks sift up or
// sift down one level at a time, a read state and a compare state per
// level, and hands one response to the output register.
// ----------------------------------------------------------------------------
module imh_ctrl import imh_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  input  stat_t st,
  output cmd_t  cmd
);
  state_t state, state_next;
  logic   ov, ov_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      ov    <= ov_next;
    end
  end
  assign rsp_valid = ov;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status = ST_OK;
    req_ready  = (state == S_IDLE);
    ov_next    = ov && !rsp_ready;
    unique case (state)
      // one key map entry per cycle after reset
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOK;
        end
      end
      // map entry of the key is on the read port
      S_LOOK: begin
        cmd.set_status = 1'b1;
        cmd.status     = ST_OK;
        unique case (st.act)
          ACT_INSERT: begin
            if (st.present) begin
              cmd.status = ST_PRESENT; state_next = S_DONE;
            end else if (st.full) begin
              cmd.status = ST_FULL; state_next = S_DONE;
            end else begin
              cmd.do_insert = 1'b1; state_next = S_UPRD;
            end
          end
          ACT_DEC: begin
            if (!st.present) begin
              cmd.status = ST_ABSENT; state_next = S_DONE;
            end else begin
              cmd.map_rd = 1'b1; state_next = S_DECIDE;
            end
          end
          ACT_POP: begin
            if (st.empty) begin
              cmd.status = ST_EMPTY; state_next = S_DONE;
            end else begin
              cmd.pop_rd = 1'b1; state_next = S_POPRD;
            end
          end
          ACT_NOP: state_next = S_DONE;
        endcase
      end
      S_DECIDE: begin
        if (st.val_zero) begin
          cmd.set_status = 1'b1; cmd.status = ST_SATURATED;
          state_next = S_DONE;
        end else begin
          cmd.do_dec = 1'b1; state_next = S_UPRD;
        end
      end
      // root and tail on the read ports
      S_POPRD: begin
        cmd.pop_take = 1'b1;
        if (st.last_zero) state_next = S_DONE;
        else state_next = S_POPWR;
      end
      S_POPWR: begin
        cmd.pop_wr = 1'b1; state_next = S_DNRD;
      end
      S_UPRD: begin
        if (st.at_root) state_next = S_DONE;
        else begin
          cmd.up_rd = 1'b1; state_next = S_UPCMP;
        end
      end
      S_UPCMP: begin
        cmd.up_rd = 1'b1;
        if (st.up_move) begin
          cmd.up_swap = 1'b1; state_next = S_UPRD;
        end else state_next = S_DONE;
      end
      S_DNRD: begin
        cmd.dn_rd = 1'b1; state_next = S_DNCMP;
      end
      S_DNCMP: begin
        cmd.dn_rd = 1'b1;
        if (st.dn_move) begin
          cmd.dn_swap = 1'b1; state_next = S_DNRD;
        end else state_next = S_DONE;
      end
      S_DONE: begin
        if (!ov || rsp_ready) begin
          cmd.out_load = 1'b1; ov_next = 1'b1; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

### design/indexed_min_heap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap: indexed binary min-heap with decrease-key
// Insert, decrement-by-key and pop-minimum over a RAM-backed heap.
// ----------------------------------------------------------------------------
// After reset the key map is cleared one key per cycle, with the request
// side held off. Then one action at a time: the accept state, a check of
// the key map and size, a slot read for a decrement or a root read and
// tail move for a pop, then per heap level of sift up a parent read and
// a compare and swap, or of sift down child reads and a compare and swap,
// the swap's second write going out in the next read state on the single
// write port of the slot RAM, and a final state that loads the response.
// A new item is taken only after the response of the last one is loaded,
// which also waits while the previous response is still held.
module indexed_min_heap import imh_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int VALUE_BITS = DEF_VAL_BITS
) (
  input logic      clk,
  input logic      rst,
  imh_req_if.sink  req,
  imh_rsp_if.source rsp
);
  cmd_t  cmd;
  stat_t st;

  imh_ctrl u_ctrl (
    .clk, .rst,
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .st, .cmd);

  imh_datapath #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst, .cmd, .st,
    .req_action(req.action), .req_key(req.entry_key), .req_value(req.entry_value),
    .rsp_key(rsp.popped_key), .rsp_value(rsp.popped_value),
    .rsp_count(rsp.entry_count), .rsp_status(rsp.status));
endmodule

### design/imh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_checker: port-level checks of the heap
// Response hold, accept spacing and status sanity.
// ----------------------------------------------------------------------------
module imh_checker import imh_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  status,
  input logic [9:0]  popped_key,
  input logic [15:0] popped_value
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable({status, popped_key, popped_value}))
    else $error("response dropped");
  a_noacc: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("accept while busy");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= ST_SATURATED)
    else $error("bad status");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> popped_key == '0 && popped_value == '0)
    else $error("popped fields set on failure");
endmodule

bind indexed_min_heap imh_checker u_chk (
  .clk, .rst,
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .status(rsp.status), .popped_key(rsp.popped_key),
  .popped_value(rsp.popped_value));

### tb/sv/indexed_min_heap_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_test: self-checking bench for the indexed min-heap
// Drives insert, decrement, pop and no-op requests with bursty gaps, stalls the
// response side, and checks every response against a behavioral heap or a typed-in expectation.
// ----------------------------------------------------------------------------
module indexed_min_heap_test;
  import imh_pkg::*;

  localparam int CAP      = 1024;
  localparam int N_DIR    = 21;
  localparam int N_DRAIN  = 200;
  localparam int N_RANDOM = 360;

  typedef struct packed {
    logic [9:0]  pkey;
    logic [15:0] pval;
    logic [10:0] count;
    logic [2:0]  status;
  } heap_rsp_t;

  typedef struct {
    action_t     act;
    logic [9:0]  key;
    logic [15:0] value;
    logic        known;   // expected response typed in below
    heap_rsp_t   rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  imh_req_if req ();
  imh_rsp_if rsp ();

  indexed_min_heap u_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // behavioral heap state
  logic [9:0]  hkey [CAP];
  logic [15:0] hval [CAP];
  int          slot_of [KEY_SPACE];
  bit          in_heap [KEY_SPACE];
  int          heap_cnt;

  heap_rsp_t pending_rsp [$];
  int        mismatches;
  bit        stim_done;

  function automatic void swap_slots(int a, int b);
    logic [9:0]  k;
    logic [15:0] v;
    k = hkey[a]; v = hval[a];
    hkey[a] = hkey[b]; hval[a] = hval[b];
    hkey[b] = k; hval[b] = v;
    slot_of[hkey[a]] = a;
    slot_of[hkey[b]] = b;
  endfunction

  function automatic void sift_toward_root(int p);
    while (p > 0 && hval[(p - 1) / 2] > hval[p]) begin
      swap_slots(p, (p - 1) / 2);
      p = (p - 1) / 2;
    end
  endfunction

  function automatic void sift_from_root();
    int p, l, pick;
    p = 0;
    forever begin
      l = 2 * p + 1;
      if (l >= heap_cnt) break;
      pick = (l + 1 < heap_cnt && hval[l + 1] < hval[l]) ? l + 1 : l;
      if (hval[pick] < hval[p]) begin
        swap_slots(p, pick);
        p = pick;
      end else break;
    end
  endfunction

  // compute the response of one action and advance the heap
  function automatic heap_rsp_t heap_apply(action_t a, logic [9:0] k, logic [15:0] v);
    heap_rsp_t r;
    r = '0;
    r.status = ST_OK;
    case (a)
      ACT_INSERT: begin
        if (in_heap[k]) r.status = ST_PRESENT;
        else if (heap_cnt >= CAP) r.status = ST_FULL;
        else begin
          hkey[heap_cnt] = k; hval[heap_cnt] = v;
          slot_of[k] = heap_cnt; in_heap[k] = 1'b1;
          heap_cnt++;
          sift_toward_root(heap_cnt - 1);
        end
      end
      ACT_DEC: begin
        if (!in_heap[k]) r.status = ST_ABSENT;
        else if (hval[slot_of[k]] == 0) r.status = ST_SATURATED;
        else begin
          hval[slot_of[k]]--;
          sift_toward_root(slot_of[k]);
        end
      end
      ACT_POP: begin
        if (heap_cnt == 0) r.status = ST_EMPTY;
        else begin
          r.pkey = hkey[0]; r.pval = hval[0];
          in_heap[hkey[0]] = 1'b0;
          heap_cnt--;
          if (heap_cnt > 0) begin
            hkey[0] = hkey[heap_cnt]; hval[0] = hval[heap_cnt];
            slot_of[hkey[0]] = 0;
            sift_from_root();
          end
        end
      end
      default: ;
    endcase
    r.count = heap_cnt[10:0];
    return r;
  endfunction

  // sender: bursts with random gaps
  int burst_left;

  task automatic send(input action_t a, input logic [9:0] k, input logic [15:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 40)) : 0;
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = int'($urandom_range(1, 30));
    end
    burst_left--;
    req.valid       <= 1'b1;
    req.action      <= a;
    req.entry_key   <= k;
    req.entry_value <= v;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic push_item(input action_t a, input logic [9:0] k, input logic [15:0] v,
                           input bit known, input heap_rsp_t exp_r);
    heap_rsp_t r;
    r = heap_apply(a, k, v);
    if (known && r !== exp_r)
      $display("directed row expectation differs from predictor: %h vs %h", exp_r, r);
    pending_rsp.push_back(known ? exp_r : r);
    send(a, k, v);
  endtask

  function automatic heap_rsp_t mk(int pk, int pv, int c, status_t s);
    heap_rsp_t r;
    r.pkey = 10'(pk); r.pval = 16'(pv); r.count = 11'(c); r.status = s;
    return r;
  endfunction

  // stimulus
  initial begin
    dir_row_t    rows [N_DIR];
    logic [9:0]  k;
    int          mode;
    action_t     a;
    req.valid = 1'b0;
    req.action = ACT_NOP;
    req.entry_key = '0;
    req.entry_value = '0;
    stim_done = 1'b0;
    burst_left = 0;
    heap_cnt = 0;
    foreach (in_heap[i]) begin
      in_heap[i] = 1'b0;
      slot_of[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table
    rows = '{
      '{ACT_POP,    10'd5,    16'd9,     1'b1, mk(0, 0, 0, ST_EMPTY)},
      '{ACT_DEC,    10'd5,    16'd0,     1'b1, mk(0, 0, 0, ST_ABSENT)},
      '{ACT_NOP,    10'h3ff,  16'hffff,  1'b1, mk(0, 0, 0, ST_OK)},
      '{ACT_INSERT, 10'h3ff,  16'hffff,  1'b1, mk(0, 0, 1, ST_OK)},
      '{ACT_INSERT, 10'h3ff,  16'd1,     1'b1, mk(0, 0, 1, ST_PRESENT)},
      '{ACT_INSERT, 10'd0,    16'd0,     1'b1, mk(0, 0, 2, ST_OK)},
      '{ACT_DEC,    10'd0,    16'd0,     1'b1, mk(0, 0, 2, ST_SATURATED)},
      '{ACT_INSERT, 10'd7,    16'd1,     1'b0, '0},
      '{ACT_INSERT, 10'd8,    16'd1,     1'b0, '0},
      '{ACT_DEC,    10'd7,    16'd0,     1'b0, '0},
      '{ACT_DEC,    10'h3ff,  16'd0,     1'b0, '0},
      '{ACT_INSERT, 10'h155,  16'haaaa,  1'b0, '0},
      '{ACT_INSERT, 10'h2aa,  16'h5555,  1'b0, '0},
      '{ACT_POP,    10'd0,    16'd0,     1'b0, '0},
      '{ACT_POP,    10'd0,    16'd0,     1'b0, '0},
      '{ACT_POP,    10'd0,    16'd0,     1'b0, '0},
      '{ACT_POP,    10'd0,    16'd0,     1'b0, '0},
      '{ACT_POP,    10'd0,    16'd0,     1'b0, '0},
      '{ACT_POP,    10'd0,    16'd0,     1'b0, '0},
      '{ACT_POP,    10'd0,    16'd0,     1'b1, mk(0, 0, 0, ST_EMPTY)},
      '{ACT_DEC,    10'h3ff,  16'd0,     1'b1, mk(0, 0, 0, ST_ABSENT)}
    };
    foreach (rows[i])
      push_item(rows[i].act, rows[i].key, rows[i].value, rows[i].known, rows[i].rsp);

    // fill to capacity with distinct keys, reinsert two present keys, then drain part
    for (int i = 0; i < CAP; i++)
      push_item(ACT_INSERT, i[9:0], 16'($urandom_range(0, 15)), 1'b0, '0);
    push_item(ACT_INSERT, 10'd3, 16'd0, 1'b0, '0);
    push_item(ACT_INSERT, 10'd0, 16'd0, 1'b0, '0);
    for (int i = 0; i < 40; i++)
      push_item(ACT_DEC, 10'($urandom), 16'($urandom), 1'b0, '0);
    for (int i = 0; i < N_DRAIN; i++)
      push_item(ACT_POP, 10'($urandom), 16'($urandom), 1'b0, '0);

    // random mix: mostly valid keys, small value ranges for ties
    for (int i = 0; i < N_RANDOM; i++) begin
      mode = $urandom_range(0, 99);
      k = 10'($urandom);
      if (mode < 40) a = ACT_INSERT;
      else if (mode < 70) a = ACT_DEC;
      else if (mode < 95) a = ACT_POP;
      else a = ACT_NOP;
      if ((a == ACT_DEC || (a == ACT_INSERT && mode < 5)) && heap_cnt > 0 &&
          $urandom_range(0, 4) != 0)
        k = hkey[$urandom_range(0, heap_cnt - 1)];
      else if (a != ACT_POP && $urandom_range(0, 1) == 1)
        k = 10'($urandom_range(0, 63));
      push_item(a, k, $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8)),
                1'b0, '0);
    end
    req.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: stall pattern
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      case ($urandom_range(0, 3))
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= ($urandom_range(0, 3) != 0);
        2: rsp.ready <= ($urandom_range(0, 3) == 0);
        default: rsp.ready <= rsp.ready;
      endcase
    end
  end

  // response check
  initial begin
    heap_rsp_t got, want;
    mismatches = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        got = {rsp.popped_key, rsp.popped_value, rsp.entry_count, rsp.status};
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response transfer: %h", got);
        end else begin
          want = pending_rsp.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: key %0d/%0d value %0d/%0d count %0d/%0d status %0d/%0d",
                       want.pkey, got.pkey, want.pval, got.pval, want.count, got.count,
                       want.status, got.status);
          end
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (pending_rsp.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
design/imh_pkg.sv
design/imh_if.sv
design/imh_ram.sv
design/imh_datapath.sv
design/imh_ctrl.sv
design/indexed_min_heap.sv
design/imh_checker.sv
tb/sv/indexed_min_heap_test.sv
